// ----- hdl/gbb_pkg.sv -----
package gbb_pkg;

    localparam int COORD_W  = 12;
    localparam int LB_W     = 14;
    localparam int ADDR_W   = 26;
    localparam int COLOR_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int WBYTES_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int FMT_W    = 2;

    localparam int MAX_COORD_DEF      = 4095;
    localparam int MAX_LINE_BYTES_DEF = 16383;

    localparam logic [FMT_W-1:0] FMT_8BPP   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_32BPP  = 2'd2;

    localparam logic [FMT_W-1:0]   RST_DEST_FORMAT = FMT_32BPP;
    localparam logic [LB_W-1:0]    RST_LINE_BYTES  = 14'd4096;
    localparam logic [COLOR_W-1:0] RST_FOREGROUND  = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND  = 32'h0000_0000;
    localparam logic [COORD_W-1:0] RST_GLYPH_WIDTH = 12'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_FORMAT,
        CFG_LINE_BYTES,
        CFG_FOREGROUND,
        CFG_BACKGROUND,
        CFG_GLYPH_LEFT,
        CFG_GLYPH_TOP,
        CFG_GLYPH_WIDTH,
        CFG_SOURCE_MONO
    } cfg_index_t;

    typedef struct packed {
        logic [FMT_W-1:0]   dest_format;
        logic [LB_W-1:0]    line_bytes;
        logic [COLOR_W-1:0] foreground_color;
        logic [COLOR_W-1:0] background_color;
        logic [COORD_W-1:0] glyph_left;
        logic [COORD_W-1:0] glyph_width;
        logic               source_mono;
    } gbb_cfg_t;

    typedef struct packed {
        logic               restart;
        logic               hold;
        logic               base_load;
        logic [ADDR_W-1:0]  base_addr;
    } gbb_ctrl_t;

    function automatic logic [COLOR_W-1:0] convert_color(logic [FMT_W-1:0] fmt,
                                                        logic [COLOR_W-1:0] c);
        logic [COLOR_W-1:0] res;
        unique case (fmt)
            FMT_8BPP:   res = {24'd0, c[7:0]};
            FMT_RGB565: res = {16'd0, c[23:19], c[15:10], c[7:3]};
            default:    res = c;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] pixel_shift(logic [FMT_W-1:0] fmt);
        logic [1:0] res;
        unique case (fmt)
            FMT_8BPP:   res = 2'd0;
            FMT_RGB565: res = 2'd1;
            default:    res = 2'd2;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/gbb_ifs.sv -----
interface gbb_glyph_if
    import gbb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] glyph_byte;

    modport source (output valid, output glyph_byte, input ready);
    modport sink   (input valid, input glyph_byte, output ready);
endinterface

interface gbb_pixel_if
    import gbb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOR_W-1:0]  pixel_value;
    logic [WBYTES_W-1:0] write_bytes;
    logic                last_of_item;

    modport source (output valid, output pixel_address, output pixel_value,
                    output write_bytes, output last_of_item, input ready);
    modport sink   (input valid, input pixel_address, input pixel_value,
                    input write_bytes, input last_of_item, output ready);
endinterface

interface gbb_cfg_if
    import gbb_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/glyph_bitmap_blitter.sv -----
// Glyph bitmap blitter: expands glyph source bytes into framebuffer pixel writes.
// The glyph channel takes one source byte per word. In mono mode the byte holds
// up to eight pixels, MSB first, and a row ends after glyph_width pixels; in
// coverage mode each byte is one pixel and a nonzero byte selects the foreground.
// The pixel channel gives one write per word: byte offset, converted color, write
// size in bytes, and a flag on the last pixel of each source byte.
// The bit shift register emits one pixel per cycle (one to eight per byte) while
// the output is not stalled; outside a recompute, the next byte is taken in the
// cycle of the last pixel of the current one. Each pixel is registered in an
// output stage that holds it while the receiver stalls, and the expansion waits
// until it is taken.
// The configuration channel writes one register per word; any write restarts the
// glyph position at its top left corner. After a write, a bit-serial multiplier
// forms the row base address; until it is done, no glyph byte and no further write
// is accepted. Reset loads the register defaults and starts at the top left
// corner with no recompute pass.
module glyph_bitmap_blitter
    import gbb_pkg::*;
#(
    parameter int MAX_COORD      = MAX_COORD_DEF,
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    gbb_cfg_if.sink     cfg,
    gbb_glyph_if.sink   glyph,
    gbb_pixel_if.source pixel
);

    gbb_cfg_t           cfg_regs;
    gbb_ctrl_t          ctrl;
    logic [COORD_W-1:0] glyph_top_reg;
    logic               start_reg;
    logic               cfg_write;
    logic               mult_busy;
    logic               mult_done;
    logic [ADDR_W-1:0]  mult_product;
    logic [COORD_W-1:0] coord_sat;
    logic [LB_W-1:0]    lb_sat;

    assign cfg.ready = !(mult_busy || start_reg);
    assign cfg_write = cfg.valid && cfg.ready;

    assign coord_sat = (32'(cfg.data[COORD_W-1:0]) > 32'(MAX_COORD))
                     ? COORD_W'(MAX_COORD) : cfg.data[COORD_W-1:0];
    assign lb_sat    = (32'(cfg.data[LB_W-1:0]) > 32'(MAX_LINE_BYTES))
                     ? LB_W'(MAX_LINE_BYTES) : cfg.data[LB_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs.dest_format      <= RST_DEST_FORMAT;
            cfg_regs.line_bytes       <= RST_LINE_BYTES;
            cfg_regs.foreground_color <= RST_FOREGROUND;
            cfg_regs.background_color <= RST_BACKGROUND;
            cfg_regs.glyph_left       <= '0;
            cfg_regs.glyph_width      <= RST_GLYPH_WIDTH;
            cfg_regs.source_mono      <= 1'b1;
            glyph_top_reg             <= '0;
            start_reg                 <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg.index))
                    CFG_DEST_FORMAT: cfg_regs.dest_format      <= cfg.data[FMT_W-1:0];
                    CFG_LINE_BYTES:  cfg_regs.line_bytes       <= lb_sat;
                    CFG_FOREGROUND:  cfg_regs.foreground_color <= cfg.data;
                    CFG_BACKGROUND:  cfg_regs.background_color <= cfg.data;
                    CFG_GLYPH_LEFT:  cfg_regs.glyph_left       <= coord_sat;
                    CFG_GLYPH_TOP:   glyph_top_reg             <= coord_sat;
                    CFG_GLYPH_WIDTH: cfg_regs.glyph_width      <= coord_sat;
                    CFG_SOURCE_MONO: cfg_regs.source_mono      <= cfg.data[0];
                endcase
            end
        end
    end

    gbb_row_mult u_row_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .top        (glyph_top_reg),
        .line_bytes (cfg_regs.line_bytes),
        .busy       (mult_busy),
        .done       (mult_done),
        .product    (mult_product)
    );

    assign ctrl.restart   = cfg_write;
    assign ctrl.hold      = mult_busy || start_reg;
    assign ctrl.base_load = mult_done;
    assign ctrl.base_addr = mult_product;

    gbb_expander #(
        .MAX_COORD (MAX_COORD)
    ) u_expander (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .ctrl     (ctrl),
        .glyph    (glyph),
        .pixel    (pixel)
    );

endmodule

// ----- hdl/gbb_row_mult.sv -----
module gbb_row_mult
    import gbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] top,
    input  logic [LB_W-1:0]    line_bytes,
    output logic               busy,
    output logic               done,
    output logic [ADDR_W-1:0]  product
);

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic [ADDR_W-1:0]  acc_reg;
    logic [ADDR_W-1:0]  mcand_reg;
    logic [COORD_W-1:0] mplier_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [ADDR_W-1:0]  acc_next;

    // One multiplier bit per cycle, least significant first.
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= ADDR_W'(line_bytes);
            mplier_reg <= top;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[ADDR_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[COORD_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hdl/gbb_expander.sv -----
module gbb_expander
    import gbb_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  gbb_cfg_t    cfg_regs,
    input  gbb_ctrl_t   ctrl,
    gbb_glyph_if.sink   glyph,
    gbb_pixel_if.source pixel
);

    localparam int ROW_W = $clog2(MAX_COORD + 1);
    localparam int IDX_W = $clog2(BYTE_W);
    localparam int OFS_W = COORD_W + 4;

    logic [BYTE_W-1:0]   bits_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                busy_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ADDR_W-1:0]   row_base_reg;
    logic [ADDR_W-1:0]   top_base_reg;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [COLOR_W-1:0]  out_value_reg;
    logic [WBYTES_W-1:0] out_bytes_reg;
    logic                out_last_reg;

    logic [COORD_W-1:0]  width_eff;
    logic                row_end;
    logic                last;
    logic                step;
    logic                accept;
    logic [1:0]          shift;
    logic [OFS_W-1:0]    col_ofs;
    logic [ADDR_W-1:0]   addr_next;

    assign width_eff = (cfg_regs.glyph_width == '0) ? COORD_W'(1) : cfg_regs.glyph_width;
    assign row_end   = ({1'b0, col_reg} + 1'b1) >= {1'b0, width_eff};
    assign last      = !cfg_regs.source_mono || (idx_reg == IDX_W'(BYTE_W - 1)) || row_end;
    assign step      = busy_reg && (!out_valid_reg || pixel.ready);
    assign glyph.ready = !ctrl.hold && (!busy_reg || (step && last));
    assign accept    = glyph.valid && glyph.ready;

    assign shift     = pixel_shift(cfg_regs.dest_format);
    assign col_ofs   = OFS_W'({1'b0, cfg_regs.glyph_left} + {1'b0, col_reg}) << shift;
    assign addr_next = row_base_reg + ADDR_W'(col_ofs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            top_base_reg  <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (ctrl.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            if (ctrl.base_load)
            begin
                row_base_reg <= ctrl.base_addr;
                top_base_reg <= ctrl.base_addr;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
                if (row_end)
                begin
                    col_reg <= '0;
                    if (row_reg == ROW_W'(MAX_COORD))
                    begin
                        row_reg      <= '0;
                        row_base_reg <= top_base_reg;
                    end
                    else
                    begin
                        row_reg      <= row_reg + 1'b1;
                        row_base_reg <= row_base_reg + ADDR_W'(cfg_regs.line_bytes);
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    // The glyph byte sits in a shift register and leaves it one bit per pixel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cfg_regs.source_mono)
            begin
                bits_reg <= glyph.glyph_byte;
            end
            else
            begin
                bits_reg <= {|glyph.glyph_byte, {(BYTE_W - 1){1'b0}}};
            end
        end
        else if (step)
        begin
            bits_reg <= {bits_reg[BYTE_W-2:0], 1'b0};
        end

        if (step)
        begin
            out_addr_reg  <= addr_next;
            out_value_reg <= convert_color(cfg_regs.dest_format,
                                           bits_reg[BYTE_W-1] ? cfg_regs.foreground_color
                                                              : cfg_regs.background_color);
            out_bytes_reg <= WBYTES_W'(1) << shift;
            out_last_reg  <= last;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_value   = out_value_reg;
    assign pixel.write_bytes   = out_bytes_reg;
    assign pixel.last_of_item  = out_last_reg;

endmodule

// ----- tb/glyph_bitmap_blitter_tb.sv -----
module glyph_bitmap_blitter_tb
    import gbb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ADDR_W-1:0]   addr;
        logic [COLOR_W-1:0]  value;
        logic [WBYTES_W-1:0] wbytes;
        logic                is_last;
    } pixel_write_t;

    logic clk;
    logic rst_n;

    gbb_cfg_if   cfg_bus ();
    gbb_glyph_if glyph_bus ();
    gbb_pixel_if pixel_bus ();

    glyph_bitmap_blitter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .glyph (glyph_bus),
        .pixel (pixel_bus)
    );

    pixel_write_t pending_pixels[$];
    int           error_count;

    logic [FMT_W-1:0]   cur_format;
    logic [LB_W-1:0]    cur_line_bytes;
    logic [COLOR_W-1:0] cur_fg;
    logic [COLOR_W-1:0] cur_bg;
    logic [COORD_W-1:0] cur_left;
    logic [COORD_W-1:0] cur_top;
    logic [COORD_W-1:0] cur_width;
    logic               cur_mono;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;

    int gap_max;
    int burst_left;
    int rx_stall_max;
    int hold_off_left;

    always #10 clk = ~clk;

    function automatic void reset_blitter_state();
        cur_format     = RST_DEST_FORMAT;
        cur_line_bytes = RST_LINE_BYTES;
        cur_fg         = RST_FOREGROUND;
        cur_bg         = RST_BACKGROUND;
        cur_left       = '0;
        cur_top        = '0;
        cur_width      = RST_GLYPH_WIDTH;
        cur_mono       = 1'b1;
        col_pos        = '0;
        row_pos        = '0;
    endfunction

    function automatic logic [WBYTES_W-1:0] bytes_per_pixel();
        case (cur_format)
            FMT_8BPP:   return 3'd1;
            FMT_RGB565: return 3'd2;
            default:    return 3'd4;
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] to_dest_color(logic [COLOR_W-1:0] c);
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
        red   = c[23:19];
        green = c[15:10];
        blue  = c[7:3];
        case (cur_format)
            FMT_8BPP:   return COLOR_W'(c[7:0]);
            FMT_RGB565: return COLOR_W'({red, green, blue});
            default:    return c;
        endcase
    endfunction

    function automatic void push_pixel(logic fg, logic is_last);
        longint unsigned x;
        longint unsigned y;
        longint unsigned addr;
        pixel_write_t    w;
        x = longint'(cur_left) + longint'(col_pos);
        y = longint'(cur_top) + longint'(row_pos);
        addr = y * longint'(cur_line_bytes) + x * longint'(bytes_per_pixel());
        w.addr    = ADDR_W'(addr);
        w.value   = to_dest_color(fg ? cur_fg : cur_bg);
        w.wbytes  = bytes_per_pixel();
        w.is_last = is_last;
        pending_pixels.push_back(w);
    endfunction

    function automatic void step_position(logic [COORD_W-1:0] w);
        col_pos = col_pos + 1'b1;
        if (col_pos >= w)
        begin
            col_pos = '0;
            row_pos = (row_pos >= COORD_W'(MAX_COORD_DEF)) ? '0 : row_pos + 1'b1;
        end
    endfunction

    function automatic void expand_glyph_byte(logic [BYTE_W-1:0] b);
        logic [COORD_W-1:0] w;
        int unsigned        cnt;
        w = (cur_width == '0) ? COORD_W'(1) : cur_width;
        if (col_pos >= w)
            col_pos = '0;
        if (!cur_mono)
        begin
            push_pixel(b != '0, 1'b1);
            step_position(w);
        end
        else
        begin
            cnt = 32'(w - col_pos);
            if (cnt > 8)
                cnt = 8;
            for (int i = 0; i < cnt; i++)
            begin
                push_pixel(b[7-i], i + 1 == cnt);
                step_position(w);
            end
        end
    endfunction

    function automatic logic [COLOR_W-1:0] with_junk(int unsigned v, int w);
        logic [COLOR_W-1:0] mask;
        mask = (COLOR_W'(1) << w) - 1'b1;
        return (COLOR_W'($urandom) & ~mask) | (COLOR_W'(v) & mask);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        glyph_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [COLOR_W-1:0] data);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_DEST_FORMAT: cur_format     = data[FMT_W-1:0];
            CFG_LINE_BYTES:  cur_line_bytes = data[LB_W-1:0];
            CFG_FOREGROUND:  cur_fg         = data;
            CFG_BACKGROUND:  cur_bg         = data;
            CFG_GLYPH_LEFT:  cur_left       = data[COORD_W-1:0];
            CFG_GLYPH_TOP:   cur_top        = data[COORD_W-1:0];
            CFG_GLYPH_WIDTH: cur_width      = data[COORD_W-1:0];
            CFG_SOURCE_MONO: cur_mono       = data[0];
            default:         ;
        endcase
        col_pos = '0;
        row_pos = '0;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_glyph(input logic [BYTE_W-1:0] b);
        int gap;
        @(negedge clk);
        gap = 0;
        if (gap_max > 0 && burst_left == 0)
        begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 12);
        end
        if (gap > 0)
        begin
            glyph_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        glyph_bus.valid      <= 1'b1;
        glyph_bus.glyph_byte <= b;
        do @(posedge clk); while (!glyph_bus.ready);
        expand_glyph_byte(b);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic test_reset_defaults();
        send_glyph(8'h80);
        send_glyph(8'h00);
        send_glyph(8'hFF);
    endtask

    task automatic test_dest_formats();
        write_reg(CFG_GLYPH_WIDTH, 32'd6);
        write_reg(CFG_FOREGROUND, 32'hA5C3_5A3C);
        write_reg(CFG_BACKGROUND, 32'h5A3C_A5C3);
        for (int f = 0; f < 4; f++)
        begin
            write_reg(CFG_DEST_FORMAT, f);
            send_glyph(8'hB4);
            send_glyph(8'h4B);
        end
    endtask

    task automatic test_row_breaks();
        write_reg(CFG_DEST_FORMAT, 32'(FMT_RGB565));
        write_reg(CFG_LINE_BYTES, 32'd100);
        write_reg(CFG_GLYPH_LEFT, 32'd7);
        write_reg(CFG_GLYPH_TOP, 32'd3);
        write_reg(CFG_GLYPH_WIDTH, 32'd11);
        send_glyph(8'hA5);
        send_glyph(8'h5A);
        send_glyph(8'hFF);
        send_glyph(8'h00);
    endtask

    task automatic test_zero_width();
        write_reg(CFG_GLYPH_WIDTH, 32'd0);
        send_glyph(8'h7F);
        send_glyph(8'h80);
    endtask

    task automatic test_coverage_mode();
        write_reg(CFG_SOURCE_MONO, 32'd0);
        write_reg(CFG_GLYPH_WIDTH, 32'd3);
        send_glyph(8'h00);
        send_glyph(8'h01);
        send_glyph(8'hFF);
        send_glyph(8'h80);
    endtask

    task automatic test_extremes();
        write_reg(CFG_SOURCE_MONO, 32'd1);
        write_reg(CFG_DEST_FORMAT, 32'(FMT_32BPP));
        write_reg(CFG_LINE_BYTES, MAX_LINE_BYTES_DEF);
        write_reg(CFG_FOREGROUND, 32'hFFFF_FFFF);
        write_reg(CFG_BACKGROUND, 32'h0000_0000);
        write_reg(CFG_GLYPH_LEFT, MAX_COORD_DEF);
        write_reg(CFG_GLYPH_TOP, MAX_COORD_DEF);
        write_reg(CFG_GLYPH_WIDTH, MAX_COORD_DEF);
        send_glyph(8'hFF);
        // The second glyph row, below the bottom edge, pushes the offset past 26 bits.
        write_reg(CFG_GLYPH_WIDTH, 32'd1);
        send_glyph(8'h00);
        send_glyph(8'h80);
        write_reg(CFG_LINE_BYTES, 32'd1);
        write_reg(CFG_GLYPH_LEFT, 32'd0);
        write_reg(CFG_GLYPH_TOP, 32'd0);
        write_reg(CFG_DEST_FORMAT, 32'(FMT_8BPP));
        send_glyph(8'h01);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_GLYPH_WIDTH, 32'd24);
        write_reg(CFG_DEST_FORMAT, 32'(FMT_RGB565));
        gap_max       = 0;
        hold_off_left = 300;
        for (int i = 0; i < 24; i++)
            send_glyph(BYTE_W'($urandom));
    endtask

    task automatic test_random_phases();
        int unsigned v;
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_DEST_FORMAT, $urandom);
            case ($urandom_range(0, 3))
                0:       v = 1;
                1:       v = MAX_LINE_BYTES_DEF;
                default: v = $urandom_range(1, 4096);
            endcase
            write_reg(CFG_LINE_BYTES, with_junk(v, LB_W));
            write_reg(CFG_FOREGROUND, $urandom);
            write_reg(CFG_BACKGROUND, $urandom);
            v = ($urandom_range(0, 3) == 0) ? MAX_COORD_DEF * $urandom_range(0, 1)
                                            : $urandom_range(0, MAX_COORD_DEF);
            write_reg(CFG_GLYPH_LEFT, with_junk(v, COORD_W));
            v = ($urandom_range(0, 3) == 0) ? MAX_COORD_DEF * $urandom_range(0, 1)
                                            : $urandom_range(0, MAX_COORD_DEF);
            write_reg(CFG_GLYPH_TOP, with_junk(v, COORD_W));
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = MAX_COORD_DEF;
                2:       v = $urandom_range(1, MAX_COORD_DEF);
                default: v = $urandom_range(1, 20);
            endcase
            write_reg(CFG_GLYPH_WIDTH, with_junk(v, COORD_W));
            write_reg(CFG_SOURCE_MONO, with_junk(($urandom_range(0, 3) != 0) ? 1 : 0, 1));
            gap_max      = (p == 0) ? 0 : $urandom_range(0, 6);
            rx_stall_max = (p == 0) ? 0 : $urandom_range(0, 10);
            for (int i = 0; i < 34; i++)
                send_glyph(BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        logic ready_state;
        int   run_left;
        ready_state = 1'b1;
        run_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                pixel_bus.ready <= 1'b0;
            end
            else if (rx_stall_max == 0)
                pixel_bus.ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    ready_state = ~ready_state;
                    run_left    = ready_state ? $urandom_range(1, 8)
                                              : $urandom_range(1, rx_stall_max);
                end
                run_left--;
                pixel_bus.ready <= ready_state;
            end
        end
    end

    initial
    begin
        pixel_write_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_bus.valid && pixel_bus.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel word with no pending write: address 0x%0h",
                           pixel_bus.pixel_address);
                    error_count++;
                end
                else
                begin
                    w = pending_pixels.pop_front();
                    check_field("pixel_address", 64'(w.addr), 64'(pixel_bus.pixel_address));
                    check_field("pixel_value", 64'(w.value), 64'(pixel_bus.pixel_value));
                    check_field("write_bytes", 64'(w.wbytes), 64'(pixel_bus.write_bytes));
                    check_field("last_of_item", 64'(w.is_last),
                                64'(pixel_bus.last_of_item));
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int drain;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_DEST_FORMAT;
        cfg_bus.data         = '0;
        glyph_bus.valid      = 1'b0;
        glyph_bus.glyph_byte = '0;
        pixel_bus.ready      = 1'b0;
        error_count          = 0;
        gap_max              = 0;
        burst_left           = 0;
        rx_stall_max         = 0;
        hold_off_left        = 0;
        reset_blitter_state();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_dest_formats();
        test_row_breaks();
        test_zero_width();
        test_coverage_mode();
        test_extremes();
        test_backpressure();
        test_random_phases();

        @(negedge clk);
        glyph_bus.valid <= 1'b0;
        drain = 0;
        while (pending_pixels.size() != 0 && drain < 20000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (32) @(negedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d pixel writes never arrived", pending_pixels.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gbb_pkg.sv
hdl/gbb_ifs.sv
hdl/gbb_row_mult.sv
hdl/gbb_expander.sv
hdl/glyph_bitmap_blitter.sv
tb/glyph_bitmap_blitter_tb.sv
